[src/stip_pkg.sv]
package stip_pkg;

    localparam int CHAR_W          = 8;
    localparam int VALUE_W         = 64;
    localparam int END_OFFSET_W    = 16;
    localparam int BASE_W          = 6;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int OFFSET_BITS_DEF = 16;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] NO_DIGIT   = 6'd36;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;

    localparam logic [APB_ADDR_W-1:0] REG_NUMBER_BASE = 3'd0;

    function automatic logic [BASE_W-1:0] f_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = c;
        if (v inside {[CH_ZERO:CH_NINE]}) begin
            return BASE_W'(v - CH_ZERO);
        end else if (v inside {[CH_LO_A:CH_LO_Z]}) begin
            return BASE_W'(v - CH_LO_A) + BASE_DEC;
        end else if (v inside {[CH_UP_A:CH_UP_Z]}) begin
            return BASE_W'(v - CH_UP_A) + BASE_DEC;
        end
        return NO_DIGIT;
    endfunction

endpackage

[src/stip_if.sv]
interface stip_char_if;
    logic                            valid;
    logic                            ready;
    logic [stip_pkg::CHAR_W-1:0]     char_code;
    logic                            start_req;

    modport source (output valid, output char_code, output start_req, input ready);
    modport sink   (input valid, input char_code, input start_req, output ready);
endinterface

interface stip_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [stip_pkg::VALUE_W-1:0]   value;
    logic [stip_pkg::END_OFFSET_W-1:0]     end_offset;

    modport source (output valid, output value, output end_offset, input ready);
    modport sink   (input valid, input value, input end_offset, output ready);
endinterface

[src/string_to_integer_parser_top.sv]
// The item that ends the parse is held in r_char, then the parse step loads r_value.
// Throughput: one item per cycle; the per-item step is one 64x6 multiply-add.
// Only the output register stalling (o_res.ready low with a result held) slows intake.
// Reset (i_rst_n low, synchronous) empties both stages, idles the parser
// and sets number_base to 10.
module string_to_integer_parser_top #(
    parameter int OFFSET_BITS = stip_pkg::OFFSET_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    stip_char_if.sink                           i_char,
    stip_res_if.source                          o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stip_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [stip_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [stip_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_LEAD   = 6'b000010,
        PH_PREFIX = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_XSEEN  = 6'b010000,
        PH_DIGITS = 6'b100000
    } t_phase;

    function automatic logic [OFFSET_BITS-1:0] f_sat_add(
        input logic [OFFSET_BITS-1:0] a,
        input logic [1:0]             n
    );
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + (OFFSET_BITS+1)'(n);
        return s[OFFSET_BITS] ? '1 : s[OFFSET_BITS-1:0];
    endfunction

    logic [stip_pkg::BASE_W-1:0]       r_number_base;
    logic                              r_in_valid;
    logic [stip_pkg::CHAR_W-1:0]       r_char;
    logic                              r_start;
    t_phase                            r_phase;
    logic [stip_pkg::BASE_W-1:0]       r_base;
    logic                              r_neg;
    logic [stip_pkg::VALUE_W-1:0]      r_acc;
    logic [OFFSET_BITS-1:0]            r_cnt;
    logic                              r_out_valid;
    logic [stip_pkg::VALUE_W-1:0]      r_value;
    logic [stip_pkg::END_OFFSET_W-1:0] r_end_offset;

    t_phase                            n_phase;
    logic [stip_pkg::BASE_W-1:0]       n_base;
    logic                              n_neg;
    logic [stip_pkg::VALUE_W-1:0]      n_acc;
    logic [OFFSET_BITS-1:0]            n_cnt;
    logic                              n_emit;
    logic [stip_pkg::VALUE_W-1:0]      n_value;
    logic [OFFSET_BITS-1:0]            n_end_cnt;

    logic                              step;
    logic                              cfg_wr;
    logic                              done;
    logic [stip_pkg::BASE_W-1:0]       dig;

    assign step        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_char.ready = !r_in_valid || step;
    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_value;
    assign o_res.end_offset = r_end_offset;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == stip_pkg::REG_NUMBER_BASE[2]);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == stip_pkg::REG_NUMBER_BASE[2]) ?
                    stip_pkg::APB_DATA_W'(r_number_base) : '0;

    always_comb begin
        n_phase   = r_phase;
        n_base    = r_base;
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_emit    = 1'b0;
        n_value   = '0;
        n_end_cnt = '0;
        done      = 1'b0;
        dig       = stip_pkg::f_digit(r_char);

        if (r_start) begin
            n_base  = r_number_base;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_cnt   = '0;
            n_phase = PH_LEAD;
            if (n_base == stip_pkg::BASE_ONE || n_base > stip_pkg::BASE_MAX) begin
                n_emit  = 1'b1;
                n_phase = PH_IDLE;
                done    = 1'b1;
            end
        end

        if (!done && n_phase == PH_LEAD) begin
            if (r_char == stip_pkg::CH_SPACE || r_char == stip_pkg::CH_TAB ||
                r_char == stip_pkg::CH_LF) begin
                n_cnt = f_sat_add(n_cnt, 2'd1);
                done  = 1'b1;
            end else begin
                n_phase = PH_PREFIX;
                if (r_char == stip_pkg::CH_MINUS || r_char == stip_pkg::CH_PLUS) begin
                    n_neg = (r_char == stip_pkg::CH_MINUS);
                    n_cnt = f_sat_add(n_cnt, 2'd1);
                    done  = 1'b1;
                end
            end
        end

        if (!done && n_phase == PH_PREFIX) begin
            done = 1'b1;
            if (r_char == stip_pkg::CH_ZERO &&
                (n_base == stip_pkg::BASE_AUTO || n_base == stip_pkg::BASE_HEX)) begin
                n_acc   = '0;
                n_cnt   = f_sat_add(n_cnt, 2'd1);
                n_phase = PH_ZERO;
            end else begin
                if (n_base == stip_pkg::BASE_AUTO) begin
                    n_base = stip_pkg::BASE_DEC;
                end
                if (dig >= n_base) begin
                    n_emit  = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_acc   = stip_pkg::VALUE_W'(dig);
                    n_cnt   = f_sat_add(n_cnt, 2'd1);
                    n_phase = PH_DIGITS;
                end
            end
        end

        if (!done && n_phase == PH_ZERO) begin
            if (r_char == stip_pkg::CH_LO_X || r_char == stip_pkg::CH_UP_X) begin
                n_base  = stip_pkg::BASE_HEX;
                n_phase = PH_XSEEN;
                done    = 1'b1;
            end else begin
                if (n_base == stip_pkg::BASE_AUTO) begin
                    n_base = stip_pkg::BASE_OCT;
                end
                n_phase = PH_DIGITS;
            end
        end

        if (!done && n_phase == PH_XSEEN) begin
            done = 1'b1;
            if (dig >= stip_pkg::BASE_HEX) begin
                n_emit    = 1'b1;
                n_end_cnt = n_cnt;
                n_phase   = PH_IDLE;
            end else begin
                n_acc   = stip_pkg::VALUE_W'(dig);
                n_cnt   = f_sat_add(n_cnt, 2'd2);
                n_phase = PH_DIGITS;
            end
        end

        if (!done && n_phase == PH_DIGITS) begin
            if (dig >= n_base) begin
                n_emit    = 1'b1;
                n_value   = n_neg ? (stip_pkg::VALUE_W'(0) - n_acc) : n_acc;
                n_end_cnt = n_cnt;
                n_phase   = PH_IDLE;
            end else begin
                n_acc = stip_pkg::VALUE_W'(n_acc * stip_pkg::VALUE_W'(n_base)) +
                        stip_pkg::VALUE_W'(dig);
                n_cnt = f_sat_add(n_cnt, 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= stip_pkg::BASE_RESET;
        end else if (cfg_wr) begin
            r_number_base <= pwdata[stip_pkg::BASE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char  <= i_char.char_code;
            r_start <= i_char.start_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_base  <= '0;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_cnt   <= '0;
        end else if (step) begin
            r_phase <= n_phase;
            r_base  <= n_base;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && n_emit) begin
            r_value      <= n_value;
            r_end_offset <= stip_pkg::END_OFFSET_W'(n_end_cnt);
        end
    end

endmodule
